### rtl/ltbr_pkg.sv
// shared types, constants and codes for the label table offset resolver
package ltbr_pkg;

	localparam int NUM_BUCKETS       = 256;
	localparam int BKT_W             = 8;
	localparam int BUCKET_DEPTH_DEF  = 128;

	localparam logic [1:0] CMD_DEFINE  = 2'd0;
	localparam logic [1:0] CMD_RESOLVE = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DUPLICATE = 2'd1;
	localparam logic [1:0] ST_UNKNOWN   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic [15:0] MASK_WIDE   = 16'h07ff;
	localparam logic [15:0] MASK_NARROW = 16'h01ff;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] label_key;
		logic [15:0] address;
		logic [15:0] base_word;
		logic        wide_offset;
	} req_t;

	typedef struct packed {
		logic [15:0] word;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [15:0] target;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_COUNT,
		S_SCAN,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic scan;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip;
		logic hit;
		logic done;
	} dp_status_t;

endpackage

### rtl/ltbr_ram.sv
// generic simple dual port ram with registered read
module ltbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/ltbr_ctrl.sv
// controller state machine for the label table offset resolver
module ltbr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	input  ltbr_pkg::dp_status_t   st,
	output ltbr_pkg::ctrl_cmd_t    cmd
);

	ltbr_pkg::state_t state_q, state_d;
	logic rsp_valid_q;
	logic out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ltbr_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ltbr_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = ltbr_pkg::S_COUNT;
				end
			end
			ltbr_pkg::S_COUNT: begin
				state_d = st.skip ? ltbr_pkg::S_FINISH : ltbr_pkg::S_SCAN;
			end
			ltbr_pkg::S_SCAN: begin
				if (st.hit || st.done) begin
					state_d = ltbr_pkg::S_FINISH;
				end
			end
			ltbr_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = ltbr_pkg::S_IDLE;
				end
			end
			default: state_d = ltbr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ltbr_pkg::S_IDLE:   cmd.load   = req_valid;
			ltbr_pkg::S_COUNT:  cmd.start  = 1'b1;
			ltbr_pkg::S_SCAN:   cmd.scan   = 1'b1;
			ltbr_pkg::S_FINISH: cmd.commit = out_free;
			default:            cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ltbr_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ltbr_pkg::S_COUNT))
		else $error("accepted transfer did not start a count read");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || !rsp_stall))
		else $error("result committed over a held transfer");

	a_rsp_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ltbr_pkg::S_FINISH))
		else $error("result raised outside finish");

endmodule

### rtl/ltbr_dpath.sv
// datapath: bucket counts, entry store, linear scan and offset math
module ltbr_dpath #(
	parameter int BUCKET_DEPTH = ltbr_pkg::BUCKET_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ltbr_pkg::req_t       req,
	output ltbr_pkg::rsp_t       rsp,
	input  ltbr_pkg::ctrl_cmd_t  cmd,
	output ltbr_pkg::dp_status_t st
);

	localparam int CNT_W  = $clog2(BUCKET_DEPTH + 1);
	localparam int ENT_AW = $clog2(ltbr_pkg::NUM_BUCKETS * BUCKET_DEPTH);

	ltbr_pkg::req_t  req_q;
	ltbr_pkg::rsp_t  rsp_q;
	ltbr_pkg::entry_t ent_rdata, ent_wdata;

	logic [ltbr_pkg::NUM_BUCKETS-1:0] cnt_valid_q;
	logic [CNT_W-1:0]  cnt_rdata, cnt_now, cnt_q, idx_q;
	logic [ENT_AW-1:0] ebase_q, ent_raddr, ent_waddr;
	logic [ltbr_pkg::BKT_W-1:0] bucket;
	logic [15:0] tgt_q, diff, mask;
	logic pend_s1, found_q, match, issue, full;
	logic ent_we, cnt_we, is_define;
	ltbr_pkg::rsp_t result;

	assign bucket    = req_q.label_key[ltbr_pkg::BKT_W-1:0];
	assign cnt_now   = cnt_valid_q[bucket] ? cnt_rdata : '0;
	assign full      = (cnt_q >= CNT_W'(BUCKET_DEPTH));
	assign is_define = (req_q.command == ltbr_pkg::CMD_DEFINE);
	assign match     = pend_s1 && (ent_rdata.key == req_q.label_key);
	assign issue     = cmd.scan && !match && (idx_q < cnt_q);

	assign st.skip = !(is_define || req_q.command == ltbr_pkg::CMD_RESOLVE)
		|| (cnt_now == '0);
	assign st.hit  = match;
	assign st.done = (idx_q >= cnt_q) && !match;

	assign ent_raddr = ebase_q + ENT_AW'(idx_q);
	assign ent_waddr = ebase_q + ENT_AW'(cnt_q);
	assign ent_we    = cmd.commit && is_define && !found_q && !full;
	assign cnt_we    = ent_we;
	assign ent_wdata = '{key: req_q.label_key, target: req_q.address};

	ltbr_ram #(
		.WIDTH(CNT_W),
		.DEPTH(ltbr_pkg::NUM_BUCKETS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(bucket),
		.wdata(cnt_q + CNT_W'(1)),
		.re   (cmd.load),
		.raddr(req.label_key[ltbr_pkg::BKT_W-1:0]),
		.rdata(cnt_rdata)
	);

	ltbr_ram #(
		.WIDTH(ltbr_pkg::ENTRY_W),
		.DEPTH(ltbr_pkg::NUM_BUCKETS * BUCKET_DEPTH)
	) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.re   (issue),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	// pc-relative offset, wraps modulo 2^16 before masking
	assign diff = tgt_q - (req_q.address + 16'd1);
	assign mask = req_q.wide_offset ? ltbr_pkg::MASK_WIDE : ltbr_pkg::MASK_NARROW;

	always_comb begin
		result = '{word: 16'd0, status: ltbr_pkg::ST_OK};
		case (req_q.command)
			ltbr_pkg::CMD_DEFINE: begin
				if (found_q) begin
					result.status = ltbr_pkg::ST_DUPLICATE;
				end else if (full) begin
					result.status = ltbr_pkg::ST_FULL;
				end
			end
			ltbr_pkg::CMD_RESOLVE: begin
				if (found_q) begin
					result.word = req_q.base_word | (diff & mask);
				end else begin
					result.status = ltbr_pkg::ST_UNKNOWN;
				end
			end
			default: result = '{word: 16'd0, status: ltbr_pkg::ST_OK};
		endcase
	end

	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_valid_q <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (cmd.start) begin
				cnt_q   <= cnt_now;
				idx_q   <= '0;
				pend_s1 <= 1'b0;
				found_q <= 1'b0;
			end
			if (cmd.scan) begin
				pend_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.commit && req_q.command == ltbr_pkg::CMD_CLEAR) begin
				cnt_valid_q <= '0;
			end else if (cnt_we) begin
				cnt_valid_q[bucket] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.start) begin
			ebase_q <= ENT_AW'(bucket) * ENT_AW'(BUCKET_DEPTH);
		end
		if (cmd.scan && match) begin
			tgt_q <= ent_rdata.target;
		end
		if (cmd.commit) begin
			rsp_q <= result;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q)
		else $error("scan pointer ran past bucket fill");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> (cnt_q < CNT_W'(BUCKET_DEPTH)))
		else $error("entry written into a full bucket");

endmodule

### rtl/label_table_branch_offset_resolver_core.sv
// top level of the label table offset resolver
//
// assembler symbol table with pc-relative branch offset resolution
// request channel (req_valid, req_stall, req): a define appends a label
// key and address to the bucket picked by the key's low byte, a resolve
// looks the key up and ors the masked offset into base_word, a clear
// empties every bucket; one response transfer follows every request
// response channel (rsp_valid, rsp_stall, rsp): word and status
// the walk reads the entries of the addressed bucket in order, all of them
// on a miss; a hit stops it early, and a clear, an unused command or an
// empty bucket skips the walk; one request is in work at a time, and
// the entry ram walk reads one bucket entry per cycle
// req_stall is high while a request is in work; a held response does not
// block the next request transfer, only the finish of that request
// reset clears all bucket fill counts (valid bits in flops), so the table
// is empty at once; the entry store is not cleared
// a stalled response holds its payload until the transfer completes
module label_table_branch_offset_resolver_core #(
	parameter int BUCKET_DEPTH = ltbr_pkg::BUCKET_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ltbr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ltbr_pkg::rsp_t rsp
);

	// command and status between controller and datapath
	ltbr_pkg::ctrl_cmd_t  cmd;
	ltbr_pkg::dp_status_t st;

	// sequencer: idle, count read, bucket scan, finish
	ltbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// storage, compare and offset arithmetic
	ltbr_dpath #(
		.BUCKET_DEPTH(BUCKET_DEPTH)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cmd   (cmd),
		.st    (st)
	);

endmodule

### tb/ltbr_response_checker.sv
// response checker for the label table offset resolver: symbol table predictor and compare
`timescale 1ns / 1ps

module ltbr_response_checker
	import ltbr_pkg::*;
#(
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	output int unsigned pending_rsps,
	output int unsigned mismatches
);

	// shadow symbol table, one row per bucket
	logic [63:0] label_keys  [NUM_BUCKETS][BUCKET_DEPTH];
	logic [15:0] label_addrs [NUM_BUCKETS][BUCKET_DEPTH];
	int unsigned bucket_fill [NUM_BUCKETS];
	rsp_t        expected_rsps[$];

	initial begin
		mismatches   = 0;
		pending_rsps = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 50)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// update the shadow table with one request and return its response
	task automatic resolve_label(input req_t item, output rsp_t result);
		logic [7:0]  bkt;
		logic [15:0] offset;
		int unsigned i;
		int unsigned slot;
		bit          hit;
		bkt  = item.label_key[7:0];
		hit  = 1'b0;
		slot = 0;
		for (i = 0; i < bucket_fill[bkt]; i++) begin
			if (!hit && label_keys[bkt][i] == item.label_key) begin
				hit  = 1'b1;
				slot = i;
			end
		end
		result.word   = '0;
		result.status = ST_OK;
		case (item.command)
			CMD_DEFINE: begin
				if (hit) begin
					result.status = ST_DUPLICATE;
				end else if (bucket_fill[bkt] >= BUCKET_DEPTH) begin
					result.status = ST_FULL;
				end else begin
					label_keys[bkt][bucket_fill[bkt]]  = item.label_key;
					label_addrs[bkt][bucket_fill[bkt]] = item.address;
					bucket_fill[bkt]++;
				end
			end
			CMD_RESOLVE: begin
				if (hit) begin
					offset = label_addrs[bkt][slot] - item.address - 16'd1;
					offset &= item.wide_offset ? MASK_WIDE : MASK_NARROW;
					result.word = item.base_word | offset;
				end else begin
					result.status = ST_UNKNOWN;
				end
			end
			CMD_CLEAR: begin
				for (i = 0; i < NUM_BUCKETS; i++)
					bucket_fill[i] = 0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUCKETS; b++)
				bucket_fill[b] = 0;
			expected_rsps.delete();
			pending_rsps = 0;
		end else begin
			// responses first: a response never belongs to a request of the same edge
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch($sformatf("response %h/%0d with nothing outstanding",
						rsp.word, rsp.status));
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.word !== want.word)
						report_mismatch($sformatf("word %h, expected %h", rsp.word, want.word));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
				end
			end
			if (req_valid && !req_stall) begin
				resolve_label(req, want);
				expected_rsps.push_back(want);
			end
			pending_rsps = expected_rsps.size();
		end
	end

endmodule

### tb/label_table_branch_offset_resolver_core_tb.sv
// testbench top for the label table offset resolver: stimulus, idling and verdict
`timescale 1ns / 1ps

module label_table_branch_offset_resolver_core_tb;
	import ltbr_pkg::*;

	// command code that the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int DEPTH        = BUCKET_DEPTH_DEF;
	localparam int FILL_ITEMS   = 180;      // long enough to overflow one bucket
	localparam int MIXED_ITEMS  = 144;
	localparam int POOL_MAX     = 400;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;

	int unsigned pending_rsps;
	int unsigned mismatches;
	int unsigned cycles = 0;

	// idling percentages, changed per phase
	int unsigned sender_idle_pct = 0;
	int unsigned rsp_stall_pct   = 0;

	// labels already defined at some point, reused for hits and duplicates
	logic [63:0] key_pool[$];

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	label_table_branch_offset_resolver_core #(
		.BUCKET_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	ltbr_response_checker #(
		.BUCKET_DEPTH(DEPTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.pending_rsps(pending_rsps),
		.mismatches  (mismatches)
	);

	// receiver back-pressure, redrawn every cycle at the falling edge
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// address and base word values, leaning on the extremes now and then
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// random label whose low byte lands in the given bucket
	function automatic logic [63:0] fresh_key(input logic [7:0] bkt);
		return {32'($urandom), 24'($urandom), bkt};
	endfunction

	function automatic req_t make_req(input logic [1:0] cmd, input logic [63:0] key,
			input logic [15:0] addr, input logic [15:0] base, input logic wide);
		req_t r;
		r.command     = cmd;
		r.label_key   = key;
		r.address     = addr;
		r.base_word   = base;
		r.wide_offset = wide;
		return r;
	endfunction

	function automatic req_t random_req(input logic [1:0] cmd, input logic [63:0] key);
		return make_req(cmd, key, pick_word(), pick_word(), 1'($urandom));
	endfunction

	// key from the pool, or a fresh one in the bucket when the pool is empty
	function automatic logic [63:0] known_key(input logic [7:0] bkt);
		if (key_pool.size() == 0)
			return fresh_key(bkt);
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	task automatic remember_key(input logic [63:0] key);
		key_pool.push_back(key);
		if (key_pool.size() > POOL_MAX)
			void'(key_pool.pop_front());
	endtask

	// one request transfer; idle cycles are inserted only before valid goes up,
	// and the payload is held until the block takes it
	task automatic push_request(input req_t item);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// mostly defines into one bucket, FILL_ITEMS requests in all, with lookups mixed in
	task automatic fill_bucket(input logic [7:0] bkt);
		logic [63:0] key;
		for (int n = 0; n < FILL_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 90) begin
				if ($urandom_range(0, 99) < 92) begin
					key = fresh_key(bkt);
					remember_key(key);
				end else begin
					key = known_key(bkt);
				end
				push_request(random_req(CMD_DEFINE, key));
			end else begin
				push_request(random_req(CMD_RESOLVE, known_key(bkt)));
			end
		end
	endtask

	// general traffic, most of it aimed at the hot bucket
	task automatic mixed_traffic(input logic [7:0] hot);
		logic [7:0]  bkt;
		logic [63:0] key;
		int unsigned pick;
		for (int n = 0; n < MIXED_ITEMS; n++) begin
			bkt  = ($urandom_range(0, 99) < 60) ? hot : 8'($urandom_range(0, 255));
			pick = $urandom_range(0, 999);
			if (pick < 5) begin
				push_request(random_req(CMD_CLEAR, fresh_key(bkt)));
			end else if (pick < 20) begin
				push_request(random_req(CMD_UNUSED, fresh_key(bkt)));
			end else if (pick < 520) begin
				// resolve: mostly labels seen before, some never defined
				key = ($urandom_range(0, 99) < 80) ? known_key(bkt) : fresh_key(bkt);
				push_request(random_req(CMD_RESOLVE, key));
			end else begin
				if ($urandom_range(0, 99) < 20) begin
					key = known_key(bkt);
				end else begin
					key = fresh_key(bkt);
					remember_key(key);
				end
				push_request(random_req(CMD_DEFINE, key));
			end
		end
	endtask

	initial begin
		logic [7:0] hot;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_stall = 1'b0;

		// single reset pulse
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, both bucket extremes, offsets at the field edges
		push_request(make_req(CMD_RESOLVE, 64'h0, 16'h0000, 16'hffff, 1'b1)); // empty table
		push_request(make_req(CMD_DEFINE, 64'h0, 16'h0000, 16'h0000, 1'b0));
		push_request(make_req(CMD_DEFINE, 64'hffff_ffff_ffff_ff00, 16'hffff, 16'hffff, 1'b1));
		push_request(make_req(CMD_DEFINE, 64'hffff_ffff_ffff_ffff, 16'h1234, 16'h0000, 1'b0));
		push_request(make_req(CMD_DEFINE, 64'h0, 16'h5555, 16'h0000, 1'b0));  // duplicate
		push_request(make_req(CMD_RESOLVE, 64'h0, 16'hffff, 16'hffff, 1'b1));
		push_request(make_req(CMD_RESOLVE, 64'h0, 16'h0000, 16'h0000, 1'b0)); // backward by one
		push_request(make_req(CMD_RESOLVE, 64'hffff_ffff_ffff_ff00, 16'hfffe, 16'h0000, 1'b1));
		push_request(make_req(CMD_RESOLVE, 64'hffff_ffff_ffff_ffff, 16'h1234, 16'hf000, 1'b0));
		// far forward distance wraps into the field
		push_request(make_req(CMD_RESOLVE, 64'hffff_ffff_ffff_ffff, 16'h0000, 16'h0000, 1'b1));
		push_request(make_req(CMD_RESOLVE, 64'hffff_ffff_ffff_ffff, 16'h8000, 16'h0a00, 1'b0));
		push_request(make_req(CMD_RESOLVE, 64'h0000_0000_0000_0100, 16'h0000, 16'hffff, 1'b1));
		// ignored command with every field set
		push_request(make_req(CMD_UNUSED, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff, 1'b1));
		push_request(make_req(CMD_CLEAR, 64'h0, 16'h0000, 16'h0000, 1'b0));
		push_request(make_req(CMD_RESOLVE, 64'h0, 16'h0000, 16'h0000, 1'b0)); // gone after clear
		push_request(make_req(CMD_DEFINE, 64'h0, 16'h8000, 16'h0000, 1'b0));  // redefine
		push_request(make_req(CMD_RESOLVE, 64'h0, 16'h7fff, 16'h0000, 1'b0)); // zero offset
		push_request(make_req(CMD_DEFINE, 64'h8000_0000_0000_0000, 16'h0100, 16'h0000, 1'b1));
		push_request(make_req(CMD_RESOLVE, 64'h8000_0000_0000_0000, 16'h0900, 16'h0000, 1'b1));
		push_request(make_req(CMD_CLEAR, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff, 1'b1));

		// random phases: none, sender idle, receiver stall, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  hot = 8'h00; end
				1: begin sender_idle_pct = 46; rsp_stall_pct = 0;  hot = 8'($urandom); end
				2: begin sender_idle_pct = 0;  rsp_stall_pct = 46; hot = 8'($urandom); end
				default: begin sender_idle_pct = 13; rsp_stall_pct = 13; hot = 8'hff; end
			endcase
			fill_bucket(hot);
			mixed_traffic(hot);
			push_request(random_req(CMD_CLEAR, fresh_key(hot)));
		end
		req_valid <= 1'b0;

		// drain, then give a late stray response time to show up
		while (pending_rsps != 0)
			@(negedge clk);
		repeat (DEPTH + 10) @(negedge clk);

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
